>>> rtl/wlpa_pkg.sv
// Package: shared types and constants of the weighted lag-profile accumulator.
package wlpa_pkg;

	localparam int NUM_BINS_DEFAULT = 1024;
	localparam int CFG_W = 12;
	localparam int CNT_W = 13;
	localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;
	localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;
	localparam logic [CFG_W-1:0] RANGE_HIGH_RESET = 12'd1024;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_RDCLR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		REG_RANGE_LOW  = 1'b0,
		REG_RANGE_HIGH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         op;
		logic               start_of_vector;
		logic signed [15:0] sample_re;
		logic signed [15:0] sample_im;
		logic [15:0]        variance;
		logic               usable;
		logic               pulse_start;
		logic [15:0]        tx_amplitude;
		logic [9:0]         bin_index;
	} in_item_t;

	typedef struct packed {
		logic               added;
		logic               zero_variance;
		logic [9:0]         bin_out;
		logic signed [63:0] sum_re;
		logic signed [63:0] sum_im;
		logic [63:0]        weight_sum;
	} out_item_t;

endpackage

>>> rtl/weighted_lag_profile_accumulator_unit.sv
// Top level of the weighted lag-profile accumulator.
// Complex lag-profile samples are sorted into range bins by a range counter
// and summed with weight w = floor(amp * 2^16 / variance); read and
// read-and-clear requests return one bin. One request is processed at a time:
// after reset a clearing pass zeroes every entry of the bin memories
// (NUM_BINS rounded up to a power of two) with in_stall high. A read, or a
// sample that adds nothing, goes through the memory read and the result
// handoff before the next acceptance; a read-and-clear adds the zero write
// following the handoff. An accumulated sample goes through the memory read
// and divider load, the bit-serial weight divider and its done flag, two
// multiply stages, the write-back of the three bin memories and the handoff.
// A finished result waits in a working register until the output register
// is free, so output stalls delay the handoff; the next request is taken
// while a result waits in the output register. Configuration is written via
// cfg_we, cfg_index and cfg_data while the block is idle.
module weighted_lag_profile_accumulator_unit #(
	parameter int NUM_BINS = wlpa_pkg::NUM_BINS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  wlpa_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output wlpa_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [11:0]          cfg_data
);
	localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int RAM_D = 1 << AW;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_READ, S_DIV, S_MUL1, S_MUL2, S_WRITE, S_OUT
	} state_t;

	state_t state_q;
	logic [AW:0] clr_q;
	logic [11:0] range_low_q, range_high_q;
	logic [12:0] cnt_q;
	logic [15:0] amp_q;
	logic [15:0] amp_use_q;
	wlpa_pkg::in_item_t req_q;
	wlpa_pkg::out_item_t wrk_q;
	wlpa_pkg::out_item_t res_q;
	logic        res_full_q;
	logic [AW-1:0] addr_q;
	logic        in_bin_q;
	logic        do_add_q;
	logic        do_clr_q;
	logic [31:0] w_q;
	logic signed [63:0] pre_s2, pim_s2;
	logic [63:0] dw_s2;

	// memory ports
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   wre, wim, wwt, rre, rim, rwt;

	// divider
	logic        div_start, div_done;
	logic [31:0] div_q;

	// accept a request only when idle; the output register decouples the result
	logic out_take;
	logic in_take;
	logic hand;
	assign out_take = out_valid && !out_stall;
	assign in_stall = !(state_q == S_IDLE);
	assign in_take  = in_valid && !in_stall;
	// move the finished result into the output register once it is free
	assign hand     = (state_q == S_OUT) && (!res_full_q || out_take);

	// range gate evaluation on the incoming request
	logic [12:0] cur_cnt;
	logic        in_gate;
	logic [12:0] offs;
	always_comb begin
		cur_cnt = in_data.start_of_vector ? ({1'b0, range_high_q} + 13'd1) : cnt_q;
		in_gate = (cur_cnt >= {1'b0, range_low_q}) && (cur_cnt < {1'b0, range_high_q});
		offs    = cur_cnt - {1'b0, range_low_q};
	end

	// decode the incoming request
	wlpa_pkg::out_item_t wrk_in;
	logic [AW-1:0] addr_in;
	logic          in_bin_in;
	logic          add_in;
	logic          clr_in;
	always_comb begin
		wrk_in    = '0;
		addr_in   = '0;
		in_bin_in = 1'b0;
		add_in    = 1'b0;
		clr_in    = 1'b0;
		unique case (wlpa_pkg::op_t'(in_data.op))
			wlpa_pkg::OP_READ, wlpa_pkg::OP_RDCLR: begin
				wrk_in.bin_out = in_data.bin_index;
				addr_in   = AW'(in_data.bin_index);
				in_bin_in = 32'(in_data.bin_index) < NUM_BINS;
				clr_in    = (in_data.op == wlpa_pkg::OP_RDCLR) && in_bin_in;
			end
			wlpa_pkg::OP_ADD: begin
				if (in_gate) begin
					wrk_in.bin_out = offs[9:0];
					addr_in   = AW'(offs);
					in_bin_in = 32'(offs) < NUM_BINS;
					if (in_bin_in && in_data.usable) begin
						if (in_data.variance == 16'd0) wrk_in.zero_variance = 1'b1;
						else add_in = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign div_start = (state_q == S_READ) && do_add_q;

	wlpa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({amp_use_q, 16'd0}),
		.divisor (req_q.variance),
		.done    (div_done),
		.quotient(div_q)
	);

	wlpa_ram #(.WIDTH(64), .DEPTH(RAM_D)) u_re (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wre), .raddr(raddr), .rdata(rre));
	wlpa_ram #(.WIDTH(64), .DEPTH(RAM_D)) u_im (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wim), .raddr(raddr), .rdata(rim));
	wlpa_ram #(.WIDTH(64), .DEPTH(RAM_D)) u_wt (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wwt), .raddr(raddr), .rdata(rwt));

	assign raddr = addr_q;

	// saturating adds of the write-back
	logic signed [64:0] sre, sim;
	logic [64:0] swt;
	logic signed [63:0] nre, nim;
	logic [63:0] nwt;
	always_comb begin
		sre = {rre[63], rre} + {pre_s2[63], pre_s2};
		sim = {rim[63], rim} + {pim_s2[63], pim_s2};
		swt = {1'b0, rwt} + {1'b0, dw_s2};
		priority if (sre[64] != sre[63]) nre = sre[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else nre = sre[63:0];
		priority if (sim[64] != sim[63]) nim = sim[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else nim = sim[63:0];
		nwt = swt[64] ? {64{1'b1}} : swt[63:0];
	end

	always_comb begin
		we = 1'b0; waddr = addr_q; wre = nre; wim = nim; wwt = nwt;
		if (state_q == S_CLEAR) begin
			we = 1'b1; waddr = clr_q[AW-1:0]; wre = '0; wim = '0; wwt = '0;
		end else if (state_q == S_WRITE && do_clr_q) begin
			we = 1'b1; wre = '0; wim = '0; wwt = '0;
		end else if (state_q == S_WRITE && do_add_q) begin
			we = 1'b1;
		end
	end

	// result as handed off: sums come from memory unless the write-back set them
	wlpa_pkg::out_item_t res_next;
	always_comb begin
		res_next = wrk_q;
		if (in_bin_q) begin
			res_next.sum_re     = rre;
			res_next.sum_im     = rim;
			res_next.weight_sum = rwt;
		end
	end

	assign out_valid = res_full_q;
	assign out_data  = res_q;

	// multiply stages
	logic signed [48:0] mre, mim;
	logic [47:0] dw_full;
	assign mre     = $signed(req_q.sample_re) * $signed({1'b0, w_q});
	assign mim     = $signed(req_q.sample_im) * $signed({1'b0, w_q});
	assign dw_full = amp_use_q * w_q;
	always_ff @(posedge clk) begin
		if (div_done) w_q <= div_q;
		if (state_q == S_MUL1) begin
			pre_s2 <= {{15{mre[48]}}, mre};
			pim_s2 <= {{15{mim[48]}}, mim};
		end
		if (state_q == S_MUL2) begin
			dw_s2 <= {32'd0, dw_full[47:16]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			range_low_q  <= '0;
			range_high_q <= wlpa_pkg::RANGE_HIGH_RESET;
			cnt_q        <= wlpa_pkg::CNT_RESET;
			amp_q        <= '0;
			amp_use_q    <= '0;
			req_q        <= '0;
			wrk_q        <= '0;
			res_q        <= '0;
			addr_q       <= '0;
			res_full_q   <= 1'b0;
			do_add_q     <= 1'b0;
			do_clr_q     <= 1'b0;
			in_bin_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (wlpa_pkg::reg_idx_t'(cfg_index))
					wlpa_pkg::REG_RANGE_LOW:  range_low_q  <= cfg_data;
					wlpa_pkg::REG_RANGE_HIGH: range_high_q <= cfg_data;
					default: ;
				endcase
			end
			if (hand) begin
				res_q      <= res_next;
				res_full_q <= 1'b1;
			end else if (out_take) begin
				res_full_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(RAM_D - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_take) begin
						req_q     <= in_data;
						amp_use_q <= amp_q;
						wrk_q     <= wrk_in;
						addr_q    <= addr_in;
						in_bin_q  <= in_bin_in;
						do_add_q  <= add_in;
						do_clr_q  <= clr_in;
						if (in_data.op == wlpa_pkg::OP_ADD) begin
							// advance the range counter
							if (in_data.pulse_start) begin
								cnt_q <= '0;
								amp_q <= in_data.tx_amplitude;
							end else if (cur_cnt < wlpa_pkg::CNT_MAX) begin
								cnt_q <= cur_cnt + 13'd1;
							end else begin
								cnt_q <= cur_cnt;
							end
						end
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// memory read is in flight this cycle
					state_q <= do_add_q ? S_DIV : S_OUT;
				end
				S_DIV: if (div_done) state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_WRITE;
				S_WRITE: begin
					if (do_clr_q) begin
						// zeros go to memory after the read result was handed off
						do_clr_q <= 1'b0;
						state_q  <= S_IDLE;
					end else begin
						// hold the new sums; memory read data is stale from here
						wrk_q    <= {1'b1, wrk_q.zero_variance, wrk_q.bin_out, nre, nim, nwt};
						do_add_q <= 1'b0;
						in_bin_q <= 1'b0;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (hand) state_q <= do_clr_q ? S_WRITE : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/wlpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module wlpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/wlpa_div.sv
// Restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
module wlpa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic [31:0] q_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;
	logic [17:0] diff;

	always_comb begin
		trial = {rem_q, q_q[31]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// shift in next dividend bit, subtract when it fits
			if (!diff[17]) begin
				rem_q <= diff[15:0];
				q_q   <= {q_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				q_q   <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = q_q;
endmodule

>>> sim/weighted_lag_profile_accumulator_unit_tb.sv
// Testbench of the weighted lag-profile accumulator: directed table plus random requests.
module weighted_lag_profile_accumulator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBINS = wlpa_pkg::NUM_BINS_DEFAULT;
	localparam int N_RANDOM = 900;
	localparam int IDLE_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	wlpa_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	wlpa_pkg::out_item_t out_data;
	logic cfg_we;
	logic cfg_index;
	logic [11:0] cfg_data;

	weighted_lag_profile_accumulator_unit #(.NUM_BINS(NBINS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the block state, advanced once per accepted request.
	logic signed [63:0] acc_re [NBINS];
	logic signed [63:0] acc_im [NBINS];
	logic [63:0] acc_wt [NBINS];
	logic [12:0] gate_count;
	logic [15:0] held_amp;
	logic [11:0] gate_low;
	logic [11:0] gate_high;

	wlpa_pkg::out_item_t pending_bins[$];
	int mismatches;
	int idle_cycles;

	// Directed table: request plus an optional fixed answer.
	typedef struct {
		wlpa_pkg::in_item_t req;
		bit fixed;
		wlpa_pkg::out_item_t ans;
	} dir_row_t;
	dir_row_t dir_rows[$];

	function automatic logic signed [63:0] sat_s(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
		return s[63:0];
	endfunction

	// Compute the answer to one request and advance the shadow state.
	function automatic wlpa_pkg::out_item_t accumulate_bin(wlpa_pkg::in_item_t r);
		wlpa_pkg::out_item_t o;
		logic [12:0] j;
		logic [31:0] w;
		logic [63:0] dw;
		logic [64:0] ws;
		o = '0;
		if (r.op == wlpa_pkg::OP_READ || r.op == wlpa_pkg::OP_RDCLR) begin
			o.bin_out = r.bin_index;
			if (r.bin_index < NBINS) begin
				o.sum_re = acc_re[r.bin_index];
				o.sum_im = acc_im[r.bin_index];
				o.weight_sum = acc_wt[r.bin_index];
				if (r.op == wlpa_pkg::OP_RDCLR) begin
					acc_re[r.bin_index] = '0;
					acc_im[r.bin_index] = '0;
					acc_wt[r.bin_index] = '0;
				end
			end
			return o;
		end
		if (r.op == wlpa_pkg::OP_NONE) return o;
		if (r.start_of_vector) gate_count = {1'b0, gate_high} + 13'd1;
		if (gate_count >= {1'b0, gate_low} && gate_count < {1'b0, gate_high}) begin
			j = gate_count - {1'b0, gate_low};
			o.bin_out = j[9:0];
			if (j < NBINS) begin
				if (r.usable) begin
					if (r.variance == 16'd0) begin
						o.zero_variance = 1'b1;
					end else begin
						w = ({16'd0, held_amp} << 16) / {16'd0, r.variance};
						acc_re[j] = sat_s(acc_re[j],
							64'($signed(r.sample_re)) * $signed({32'd0, w}));
						acc_im[j] = sat_s(acc_im[j],
							64'($signed(r.sample_im)) * $signed({32'd0, w}));
						dw = (64'(held_amp) * 64'(w)) >> 16;
						ws = {1'b0, acc_wt[j]} + {1'b0, dw};
						acc_wt[j] = ws[64] ? '1 : ws[63:0];
						o.added = 1'b1;
					end
				end
				o.sum_re = acc_re[j];
				o.sum_im = acc_im[j];
				o.weight_sum = acc_wt[j];
			end
		end
		if (r.pulse_start) begin
			gate_count = '0;
			held_amp = r.tx_amplitude;
		end else if (gate_count < wlpa_pkg::CNT_MAX) begin
			gate_count = gate_count + 13'd1;
		end
		return o;
	endfunction

	function automatic wlpa_pkg::in_item_t rand_req();
		wlpa_pkg::in_item_t r;
		logic [95:0] raw;
		int pick;
		raw = {$urandom, $urandom, $urandom};
		r = raw[$bits(wlpa_pkg::in_item_t)-1:0];
		pick = $urandom_range(0, 99);
		// Mostly adds: pulses, vector starts and mostly usable samples.
		if (pick < 80) begin
			r.op = wlpa_pkg::OP_ADD;
			r.start_of_vector = ($urandom_range(0, 60) == 0);
			r.pulse_start = ($urandom_range(0, 15) == 0);
			r.usable = ($urandom_range(0, 7) != 0);
			if ($urandom_range(0, 19) == 0) r.variance = '0;
			else if ($urandom_range(0, 3) == 0) r.variance = 16'($urandom_range(1, 8));
		end else if (pick < 95) begin
			r.op = ($urandom_range(0, 1) != 0) ? wlpa_pkg::OP_READ : wlpa_pkg::OP_RDCLR;
			r.bin_index = 10'($urandom_range(0, 40));
		end
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: stall on its own pattern and check every accepted result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			case ($urandom_range(0, 3))
				0: out_stall <= ($urandom_range(0, 1) != 0);
				default: out_stall <= out_stall & ($urandom_range(0, 2) != 0);
			endcase
			if (out_valid && !out_stall) begin
				if (pending_bins.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", out_data);
				end else begin
					wlpa_pkg::out_item_t e;
					e = pending_bins.pop_front();
					if (e !== out_data) begin
						mismatches++;
						if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data);
					end
				end
			end
		end
	end

	// Watchdog on cycles with no accepted request or result.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > IDLE_LIMIT) begin
				$display("weighted_lag_profile_accumulator_unit_tb failed");
				$finish;
			end
		end
	end

	// Hold a request until the block takes it, then log its expected answer.
	task automatic issue_request(wlpa_pkg::in_item_t r, bit fixed, wlpa_pkg::out_item_t ans);
		wlpa_pkg::out_item_t e;
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		e = accumulate_bin(r);
		if (fixed && e !== ans) begin
			mismatches++;
			if (mismatches <= 10) $display("table row disagrees: %p vs %p", ans, e);
		end
		pending_bins.push_back(e);
		// Random gaps between bursts.
		if ($urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_bins.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_gate(logic [11:0] lo, logic [11:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= wlpa_pkg::REG_RANGE_LOW;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= wlpa_pkg::REG_RANGE_HIGH;
		cfg_data <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		gate_low = lo;
		gate_high = hi;
	endtask

	function automatic dir_row_t mk(logic [1:0] op, bit sv, int re, int im, int var_v, bit us,
			bit pu, int amp, int bin, bit fixed, wlpa_pkg::out_item_t ans);
		dir_row_t d;
		d.req = '{op: op, start_of_vector: sv, sample_re: re[15:0], sample_im: im[15:0],
			variance: var_v[15:0], usable: us, pulse_start: pu, tx_amplitude: amp[15:0],
			bin_index: bin[9:0]};
		d.fixed = fixed;
		d.ans = ans;
		return d;
	endfunction

	initial begin
		wlpa_pkg::out_item_t z;
		wlpa_pkg::out_item_t zv;
		dir_row_t d;
		logic [11:0] lo_set [4];
		logic [11:0] hi_set [4];
		z = '0;
		zv = '0;
		zv.zero_variance = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = wlpa_pkg::REG_RANGE_LOW;
		cfg_data = '0;
		mismatches = 0;
		idle_cycles = 0;
		for (int i = 0; i < NBINS; i++) begin
			acc_re[i] = '0;
			acc_im[i] = '0;
			acc_wt[i] = '0;
		end
		gate_count = wlpa_pkg::CNT_RESET;
		held_amp = '0;
		gate_low = '0;
		gate_high = wlpa_pkg::RANGE_HIGH_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset: reads see zero, adds before any pulse land outside the gate.
		dir_rows.push_back(mk(wlpa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, z));
		dir_rows.push_back(mk(wlpa_pkg::OP_ADD, 0, 32767, -32768, 1, 1, 0, 0, 0, 1, z));
		dir_rows.push_back(mk(wlpa_pkg::OP_NONE, 1, -1, -1, 65535, 1, 1, 65535, 1023, 1, z));
		dir_rows.push_back(mk(wlpa_pkg::OP_ADD, 1, 5, 5, 5, 1, 0, 0, 0, 1, z));
		// Pulse with full amplitude, then in-gate extremes of sample and variance.
		dir_rows.push_back(mk(wlpa_pkg::OP_ADD, 0, 0, 0, 7, 0, 1, 65535, 0, 1, z));
		dir_rows.push_back(mk(wlpa_pkg::OP_ADD, 0, 32767, -32768, 1, 1, 0, 0, 0, 0, z));
		dir_rows.push_back(mk(wlpa_pkg::OP_ADD, 0, -32768, 32767, 65535, 1, 0, 0, 0, 0, z));
		dir_rows.push_back(mk(wlpa_pkg::OP_ADD, 0, 100, 100, 0, 1, 0, 0, 0, 1,
			'{0, 1, 2, 0, 0, 0}));
		dir_rows.push_back(mk(wlpa_pkg::OP_ADD, 0, 100, 100, 9, 0, 0, 0, 0, 0, z));
		dir_rows.push_back(mk(wlpa_pkg::OP_ADD, 0, 32767, 32767, 1, 1, 1, 0, 0, 0, z));
		// Zero amplitude adds with zero weight.
		dir_rows.push_back(mk(wlpa_pkg::OP_ADD, 0, 32767, 32767, 1, 1, 0, 0, 0, 0, z));
		dir_rows.push_back(mk(wlpa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, z));
		dir_rows.push_back(mk(wlpa_pkg::OP_RDCLR, 0, 0, 0, 0, 0, 0, 0, 1, 0, z));
		dir_rows.push_back(mk(wlpa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 1,
			'{0, 0, 1, 0, 0, 0}));
		dir_rows.push_back(mk(wlpa_pkg::OP_RDCLR, 0, 0, 0, 0, 0, 0, 0, 1023, 0, z));
		// Counter reset by a new vector: outside the gate until the next pulse.
		dir_rows.push_back(mk(wlpa_pkg::OP_ADD, 1, 1, 1, 1, 1, 0, 0, 0, 1, z));
		foreach (dir_rows[i]) issue_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].ans);

		// Full-scale samples at unit variance into bin 0, then read and clear it.
		drain_results();
		for (int i = 0; i < 5; i++) begin
			d = mk(wlpa_pkg::OP_ADD, 0, 0, 0, 1, 0, 1, 65535, 0, 0, z);
			issue_request(d.req, 0, z);
			d = mk(wlpa_pkg::OP_ADD, 0, (i % 2) ? -32768 : 32767, -32768, 1, 1, 0, 0, 0,
				0, z);
			issue_request(d.req, 0, z);
		end
		d = mk(wlpa_pkg::OP_RDCLR, 0, 0, 0, 0, 0, 0, 0, 0, 0, z);
		issue_request(d.req, 0, z);
		drain_results();

		// Gate settings: narrow, offset, empty, and extremes (bins beyond the array).
		lo_set = '{12'd0, 12'd2000, 12'd100, 12'd0};
		hi_set = '{12'd32, 12'd2040, 12'd100, 12'd4095};
		for (int ph = 0; ph < 4; ph++) begin
			write_gate(lo_set[ph], hi_set[ph]);
			for (int n = 0; n < N_RANDOM / 4; n++) begin
				wlpa_pkg::in_item_t r;
				r = rand_req();
				// Far gates need the counter to climb: favor long runs without pulses.
				if (ph != 0 && r.pulse_start && $urandom_range(0, 7) != 0) r.pulse_start = 1'b0;
				issue_request(r, 0, z);
			end
			drain_results();
		end
		write_gate(12'd4095, 12'd0);
		for (int n = 0; n < 20; n++) issue_request(rand_req(), 0, z);
		drain_results();

		if (mismatches == 0) $display("weighted_lag_profile_accumulator_unit_tb passed");
		else $display("weighted_lag_profile_accumulator_unit_tb failed");
		$finish;
	end
endmodule
